[hdl/rbf_pkg.sv]
// Package for the received-byte ring FIFO: sizing constants, item kind codes,
// the per-cell control struct and the fill-count saturation function.
// No dependencies; used by rbf_cell and rx_byte_ring_fifo.
package rbf_pkg;

  localparam int RING_DEPTH = 256;
  localparam int MAX_BURST  = 16;

  // The ring holds one byte less than its depth, one cell per stored byte.
  localparam int NUM_CELLS = RING_DEPTH - 1;
  localparam int FILL_W    = $clog2(RING_DEPTH);
  localparam int BURST_W   = $clog2(MAX_BURST + 1);
  localparam int LEN_W     = 5;
  localparam int CMP_W     = (LEN_W > BURST_W) ? LEN_W : BURST_W;
  localparam int SAT_W     = (FILL_W > 8) ? FILL_W : 8;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NOP   = 2'd3
  } kind_e;

  // Broadcast control for the cell chain.
  typedef struct packed {
    logic       shift;    // every cell takes its upper neighbor's byte
    logic       load;     // the selected cell takes wr_data
    logic [7:0] wr_data;
  } cell_ctl_t;

  // Fill count as reported on the result port, saturated to one byte.
  function automatic logic [7:0] sat_fill(input logic [FILL_W-1:0] fill);
    logic [SAT_W-1:0] wide;
    wide = SAT_W'(fill);
    return (wide > SAT_W'(255)) ? 8'hFF : wide[7:0];
  endfunction

endpackage

[hdl/rbf_cell.sv]
// One storage cell of the FIFO chain: holds a byte, shifts it toward the
// head on a read, or loads a pushed byte when it is the tail. Uses rbf_pkg.
module rbf_cell (
  input  logic              clk_i,
  input  rbf_pkg::cell_ctl_t ctl_i,
  input  logic              sel_i,
  input  logic [7:0]        up_data_i,
  output logic [7:0]        data_o
);

  logic [7:0] data_q;
  logic [7:0] data_d;

  always_comb begin
    data_d = data_q;
    if (ctl_i.shift) begin
      data_d = up_data_i;
    end else if (ctl_i.load && sel_i) begin
      data_d = ctl_i.wr_data;
    end
  end

  // Stored bytes are payload only and need no reset.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

[hdl/rx_byte_ring_fifo.sv]
// Received-byte FIFO: top level with the command controller and the cell chain.
// Depends on rbf_pkg and rbf_cell.
//
// Usage: an item is taken at a rising edge where start is high and busy is
// low. kind_i selects push (store rx_data_i), read (deliver up to read_len_i
// bytes, capped at MAX_BURST) or clear (empty the FIFO, drop the overflow
// flag); the fourth code does nothing. Results appear on the out_* ports for
// exactly one cycle, marked by out_valid_o; the receiver cannot stall them.
// Every result carries the fill count and the sticky overflow flag.
// Each result is registered and appears in the cycle after the edge that
// caused it. Push, clear and no-op items may follow back to back. A read of
// N bytes delivers one byte per cycle, with busy high while its later bytes
// leave the head; an empty FIFO or a zero request answers with one result
// without data. The byte rate is set by the head cell of the chain, which
// presents one byte per shift.
// Bytes sit in a chain of RING_DEPTH-1 cells: a read takes the head cell and
// shifts the chain by one, a push loads the cell just past the last byte.
// Reset clears the fill count, the overflow flag and the controller; stored
// bytes are left as they are, and no clearing pass is needed.
module rx_byte_ring_fifo (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] kind_i,
  input  logic [7:0] rx_data_i,
  input  logic [4:0] read_len_i,
  output logic       out_valid_o,
  output logic [7:0] out_data_o,
  output logic       data_valid_o,
  output logic       last_o,
  output logic [7:0] fill_count_o,
  output logic       overflow_o
);

  typedef enum logic {
    ST_IDLE,
    ST_BURST
  } state_e;

  state_e                       state_q, state_d;
  logic [rbf_pkg::BURST_W-1:0]  rem_q, rem_d;
  logic [rbf_pkg::FILL_W-1:0]   fill_q, fill_d;
  logic                         ovf_q, ovf_d;
  logic                         out_valid_q, out_valid_d;
  logic                         last_q, last_d;
  logic                         dvalid_q, dvalid_d;
  logic [7:0]                   out_data_q, out_data_d;

  logic                         accept;
  logic                         full;
  logic                         empty;
  logic [rbf_pkg::BURST_W-1:0]  want;
  logic [rbf_pkg::BURST_W-1:0]  cnt;
  logic                         emit_byte;
  logic                         is_last;
  rbf_pkg::cell_ctl_t           ctl;
  logic [7:0]                   cell_data [rbf_pkg::NUM_CELLS];

  assign busy   = (state_q == ST_BURST);
  assign accept = start && !busy;
  assign full   = (fill_q == rbf_pkg::FILL_W'(rbf_pkg::NUM_CELLS));
  assign empty  = (fill_q == '0);

  assign want = (rbf_pkg::CMP_W'(read_len_i) > rbf_pkg::CMP_W'(rbf_pkg::MAX_BURST))
              ? rbf_pkg::BURST_W'(rbf_pkg::MAX_BURST)
              : rbf_pkg::BURST_W'(read_len_i);

  assign cnt = busy ? rem_q : want;

  // A byte leaves the head either while a burst runs or on the edge that
  // accepts a read with something to deliver.
  assign emit_byte = busy || (accept && (kind_i == rbf_pkg::KIND_READ) &&
                              (want != '0) && !empty);
  assign is_last   = (cnt == rbf_pkg::BURST_W'(1)) ||
                     (fill_q == rbf_pkg::FILL_W'(1));

  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    fill_d      = fill_q;
    ovf_d       = ovf_q;
    out_valid_d = 1'b0;
    last_d      = last_q;
    dvalid_d    = dvalid_q;
    out_data_d  = out_data_q;
    ctl.shift   = 1'b0;
    ctl.load    = 1'b0;
    ctl.wr_data = rx_data_i;

    if (emit_byte) begin
      ctl.shift   = 1'b1;
      fill_d      = fill_q - rbf_pkg::FILL_W'(1);
      rem_d       = cnt - rbf_pkg::BURST_W'(1);
      out_valid_d = 1'b1;
      dvalid_d    = 1'b1;
      out_data_d  = cell_data[0];
      last_d      = is_last;
      state_d     = is_last ? ST_IDLE : ST_BURST;
    end else if (accept) begin
      out_valid_d = 1'b1;
      dvalid_d    = 1'b0;
      out_data_d  = 8'h00;
      last_d      = 1'b1;
      case (kind_i)
        rbf_pkg::KIND_PUSH: begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            ctl.load = 1'b1;
            fill_d   = fill_q + rbf_pkg::FILL_W'(1);
          end
        end
        rbf_pkg::KIND_CLEAR: begin
          fill_d = '0;
          ovf_d  = 1'b0;
        end
        // A read with nothing to deliver and the no-op both leave state alone.
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rem_q       <= '0;
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      dvalid_q    <= 1'b0;
      out_data_q  <= 8'h00;
    end else begin
      state_q     <= state_d;
      rem_q       <= rem_d;
      fill_q      <= fill_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
      dvalid_q    <= dvalid_d;
      out_data_q  <= out_data_d;
    end
  end

  // Cell chain: cell 0 is the head; the tail cell is the one at the fill count.
  for (genvar i = 0; i < rbf_pkg::NUM_CELLS; i++) begin : g_cell
    logic       sel;
    logic [7:0] up_data;

    assign sel = (fill_q == rbf_pkg::FILL_W'(i));
    if (i == rbf_pkg::NUM_CELLS - 1) begin : g_top
      assign up_data = 8'h00;
    end else begin : g_mid
      assign up_data = cell_data[i + 1];
    end

    rbf_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .sel_i     (sel),
      .up_data_i (up_data),
      .data_o    (cell_data[i])
    );
  end

  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_data_q;
  assign data_valid_o = dvalid_q;
  assign last_o       = last_q;
  assign fill_count_o = rbf_pkg::sat_fill(fill_q);
  assign overflow_o   = ovf_q;

  // A burst only runs while there are bytes left to deliver.
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy |-> (fill_q != '0))
    else $error("burst running on an empty FIFO");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   fill_q <= rbf_pkg::FILL_W'(rbf_pkg::NUM_CELLS))
    else $error("fill count beyond capacity");

  // A result without data always ends its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_o && !data_valid_o) |-> last_o)
    else $error("result without data not marked last");

  // A result that is not last is followed by the next byte of the burst.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_o && !last_o) |=> (out_valid_o && data_valid_o))
    else $error("burst interrupted");

  // The overflow flag sets only on a push that found the FIFO full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (!ovf_q ##1 ovf_q) |->
                   $past(accept && (kind_i == rbf_pkg::KIND_PUSH) && full))
    else $error("overflow set without a dropped push");

endmodule
